### rtl/iqs_pkg.sv
`default_nettype none
package iqs_pkg;
  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_POP_RD, ST_POP, ST_PIV_RD, ST_PIV, ST_SCAN_I, ST_SCAN_J, ST_SWAP_WR,
    ST_SWAP_RD, ST_PUSH, ST_PUSH_R, ST_OUT_RD, ST_OUT
  } sort_state_t;
endpackage
`default_nettype wire

### rtl/iterative_quicksort_top.sv
`default_nettype none
// loading: each word is captured into the queue, then moved from queue to store; busy holds off the next word meanwhile
// after the last word leaves the queue, each range passes pop_rd, pop, piv_rd and piv, then scan steps, swaps
//   of two writes and a read, and pushes of left then right; n log n scan steps on average, n*n at worst
// then the out_rd state and one result word per cycle, the receiver cannot stall them
// busy is high from the last word through the cycle of the final result word
// rst is synchronous and clears count, stack pointer, flags and the queue
module iterative_quicksort_top import iqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  input  wire in_word_t  in_word,
  output logic           done,
  output out_word_t      out_word
);
  logic q_valid, q_last, pop, sorting, res_last, res_ovf, take;
  logic [DATA_WIDTH-1:0] q_value, res_value;
  logic last_seen;

  assign take = start && !busy;

  // hold off new words from the moment a last word is captured until sort ends
  always_ff @(posedge clk) begin
    if (rst) last_seen <= 1'b0;
    else if (take && in_word.last_in) last_seen <= 1'b1;
    else if (done && res_last) last_seen <= 1'b0;
  end
  assign busy = last_seen || sorting || q_valid;

  iqs_front u_front (
    .clk, .rst, .take, .value(in_word.value), .last_in(in_word.last_in),
    .pop, .q_valid, .q_value, .q_last
  );

  iqs_back #(.DEPTH(DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_value, .q_last, .pop, .sorting,
    .res_valid(done), .res_value, .res_last, .res_ovf
  );

  assign out_word.sorted_value = res_value;
  assign out_word.last_out     = res_last;
  assign out_word.overflow     = res_ovf;
endmodule
`default_nettype wire

### rtl/iqs_front.sv
`default_nettype none
module iqs_front import iqs_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [DATA_WIDTH-1:0] value,
  input  wire logic                  last_in,
  input  wire logic                  pop,
  output logic                       q_valid,
  output logic [DATA_WIDTH-1:0]      q_value,
  output logic                       q_last
);
  // two-entry queue between input capture and the store writer
  logic [DATA_WIDTH-1:0] qv [2];
  logic                  ql [2];
  logic [1:0]            cnt;
  logic                  rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      rd  <= 1'b0;
    end else begin
      if (pop && cnt != 2'd0) rd <= ~rd;
      cnt <= cnt + 2'(take) - 2'(pop && cnt != 2'd0);
    end
    if (take) begin
      qv[rd ^ (cnt != 2'd0) ^ (pop && cnt != 2'd0)] <= value;
      ql[rd ^ (cnt != 2'd0) ^ (pop && cnt != 2'd0)] <= last_in;
    end
  end

  assign q_valid = (cnt != 2'd0);
  assign q_value = qv[rd];
  assign q_last  = ql[rd];
endmodule
`default_nettype wire

### rtl/iqs_back.sv
`default_nettype none
module iqs_back import iqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire logic [DATA_WIDTH-1:0] q_value,
  input  wire logic                  q_last,
  output logic                       pop,
  output logic                       sorting,
  output logic                       res_valid,
  output logic [DATA_WIDTH-1:0]      res_value,
  output logic                       res_last,
  output logic                       res_ovf
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = AW + 2;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [2*AW-1:0]       stk [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [2*AW-1:0]       sdata;

  sort_state_t state, state_next;
  logic [CW-1:0] count, sp, load_n;
  logic          dropped;
  logic [AW-1:0] lo, hi, raddr, waddr;
  // scan indices are signed and two bits wider: i may pass hi, j may drop below lo
  logic signed [IW-1:0] i, j, lo_s, hi_s;
  logic [AW:0]   mid_sum;
  logic [DATA_WIDTH-1:0] pivot, ei, ej;
  logic          we;
  logic [DATA_WIDTH-1:0] wdata;
  logic          swap_phase;
  logic          scan_i_go, scan_j_go, last_idx;

  // sign-flipped compare
  function automatic logic lt(input logic [DATA_WIDTH-1:0] a, b);
    lt = {~a[DATA_WIDTH-1], a[DATA_WIDTH-2:0]} < {~b[DATA_WIDTH-1], b[DATA_WIDTH-2:0]};
  endfunction

  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign lo_s      = $signed({2'b00, lo});
  assign hi_s      = $signed({2'b00, hi});
  assign scan_i_go = (i < hi_s) && lt(rdata, pivot);
  assign scan_j_go = (j > lo_s) && lt(pivot, rdata);
  assign load_n    = count + CW'(count != CW'(DEPTH));
  assign last_idx  = (i[AW-1:0] == AW'(count - CW'(1))) || count == CW'(1);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
  always_ff @(posedge clk) sdata <= stk[sp[AW-1:0] - AW'(1)];

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:    if (q_valid && q_last)
                    state_next = (load_n >= CW'(2)) ? ST_POP_RD : ST_OUT_RD;
      ST_POP_RD:  state_next = (sp == '0) ? ST_OUT_RD : ST_POP;
      ST_POP:     state_next = ST_PIV_RD;
      ST_PIV_RD:  state_next = ST_PIV;
      ST_PIV:     state_next = ST_SCAN_I;
      ST_SCAN_I:  if (!scan_i_go) state_next = ST_SCAN_J;
      ST_SCAN_J:  if (!scan_j_go)
                    state_next = (i <= j) ? ST_SWAP_WR : ST_PUSH;
      ST_SWAP_WR: state_next = (swap_phase) ? ST_SWAP_RD : ST_SWAP_WR;
      ST_SWAP_RD: state_next = (i <= j) ? ST_SCAN_I : ST_PUSH;
      ST_PUSH:    state_next = ST_PUSH_R;
      ST_PUSH_R:  state_next = ST_POP_RD;
      ST_OUT_RD:  state_next = ST_OUT;
      ST_OUT:     if (last_idx) state_next = ST_LOAD;
      default:    state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    pop = (state == ST_LOAD) && q_valid;
    sorting = (state != ST_LOAD);
    we = 1'b0; waddr = i[AW-1:0]; wdata = ej;
    raddr = i[AW-1:0];
    case (state)
      ST_LOAD:    begin we = q_valid && count != CW'(DEPTH); waddr = count[AW-1:0];
                        wdata = q_value; end
      ST_PIV_RD:  raddr = mid_sum[AW:1];
      ST_SCAN_I:  raddr = scan_i_go ? i[AW-1:0] + AW'(1) : j[AW-1:0];
      ST_SCAN_J:  raddr = scan_j_go ? j[AW-1:0] - AW'(1) : i[AW-1:0];
      ST_SWAP_WR: begin we = 1'b1; waddr = swap_phase ? j[AW-1:0] : i[AW-1:0];
                        wdata = swap_phase ? ei : ej; end
      ST_OUT_RD:  raddr = '0;
      ST_OUT:     raddr = i[AW-1:0] + AW'(1);
      default:    raddr = i[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD; count <= '0; dropped <= 1'b0; sp <= '0;
      res_valid <= 1'b0; swap_phase <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= 1'b0;
      case (state)
        ST_LOAD: if (q_valid) begin
          if (count != CW'(DEPTH)) count <= count + CW'(1);
          else dropped <= 1'b1;
          if (q_last) begin
            stk[0] <= {AW'(0), AW'(load_n - CW'(1))};
            sp <= (load_n >= CW'(2)) ? CW'(1) : CW'(0);
            i <= '0;
          end
        end
        // stack top is read during pop_rd, so it is valid in pop
        ST_POP_RD: if (sp == '0) i <= '0;
        ST_POP: begin
          sp <= sp - CW'(1);
          lo <= sdata[2*AW-1:AW]; hi <= sdata[AW-1:0];
          i <= $signed({2'b00, sdata[2*AW-1:AW]});
          j <= $signed({2'b00, sdata[AW-1:0]});
        end
        ST_PIV:    pivot <= rdata;
        ST_SCAN_I: if (scan_i_go) i <= i + IW'(1); else ei <= rdata;
        ST_SCAN_J: if (scan_j_go) j <= j - IW'(1); else ej <= rdata;
        ST_SWAP_WR: begin
          swap_phase <= ~swap_phase;
          if (swap_phase) begin
            i <= i + IW'(1);
            j <= j - IW'(1);
          end
        end
        // left part first, right part on the next cycle
        ST_PUSH: if (lo_s < j) begin
          stk[sp[AW-1:0]] <= {lo, j[AW-1:0]};
          sp <= sp + CW'(1);
        end
        ST_PUSH_R: if (i < hi_s) begin
          stk[sp[AW-1:0]] <= {i[AW-1:0], hi};
          sp <= sp + CW'(1);
        end
        ST_OUT: begin
          res_valid <= 1'b1;
          res_value <= rdata;
          res_ovf   <= dropped;
          res_last  <= last_idx;
          i <= i + IW'(1);
          if (last_idx) begin
            count <= '0; dropped <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst) sp <= CW'(DEPTH))
    else $error("range stack overrun");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("count overrun");
  a_out_only: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(state) == ST_OUT) else $error("stray result");
`endif
endmodule
`default_nettype wire

### bench/tb_top.sv
module tb_top;
  import iqs_pkg::*;

  localparam int STORE_DEPTH = 64;
  // quiet cycles after the last expected word, to catch stray results
  localparam int SETTLE_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  in_word_t in_word = '0;
  out_word_t out_word;

  always #4 clk = ~clk;

  iterative_quicksort_top DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .done(done),
    .out_word(out_word)
  );

  // shadow copy of the block's element store
  logic signed [31:0] shadow_store[$];
  logic shadow_dropped = 1'b0;
  out_word_t sorted_queue[$];
  int errors = 0;
  int idle_pct = 0;

  // directed table: value, last flag
  in_word_t directed[$];

  // hoare quicksort on the shadow set, pushes one result word per element
  task automatic sort_and_queue();
    logic signed [31:0] arr[$];
    int lo_stk[$];
    int hi_stk[$];
    int lo, hi, i, j, n;
    logic signed [31:0] pivot, t;
    arr = shadow_store;
    n = arr.size();
    if (n >= 2) begin
      lo_stk.push_back(0);
      hi_stk.push_back(n - 1);
    end
    while (lo_stk.size() > 0) begin
      lo = lo_stk.pop_back();
      hi = hi_stk.pop_back();
      if (lo >= hi) continue;
      pivot = arr[(lo + hi) / 2];
      i = lo;
      j = hi;
      while (i <= j) begin
        while (i < hi && arr[i] < pivot) i++;
        while (j > lo && arr[j] > pivot) j--;
        if (i <= j) begin
          t = arr[i];
          arr[i] = arr[j];
          arr[j] = t;
          i++;
          j--;
        end
      end
      if (lo < j) begin
        lo_stk.push_back(lo);
        hi_stk.push_back(j);
      end
      if (i < hi) begin
        lo_stk.push_back(i);
        hi_stk.push_back(hi);
      end
    end
    for (int k = 0; k < n; k++) begin
      out_word_t w;
      w.sorted_value = arr[k];
      w.last_out = (k == n - 1);
      w.overflow = shadow_dropped;
      sorted_queue.push_back(w);
    end
    shadow_store.delete();
    shadow_dropped = 1'b0;
  endtask

  task automatic predict_word(input in_word_t w);
    if (shadow_store.size() < STORE_DEPTH) shadow_store.push_back(w.value);
    else shadow_dropped = 1'b1;
    if (w.last_in) sort_and_queue();
  endtask

  // send one word, with random idle before it at the phase's rate
  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(w);
  endtask

  // set of len words with random content; mode picks the value spread
  task automatic send_set(input int len, input int mode);
    in_word_t w;
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: w.value = $urandom;
        1: w.value = $signed($urandom_range(7)) - 3;
        default: w.value = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      endcase
      w.last_in = (k == len - 1);
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sorted_queue.size() > 0) @(posedge clk);
  endtask

  // result checking, done marks each result word
  always @(posedge clk) begin
    if (!rst && done) begin
      if (sorted_queue.size() == 0) begin
        $error("result word with nothing expected: %0d", out_word.sorted_value);
        errors++;
      end else begin
        out_word_t e;
        e = sorted_queue.pop_front();
        if (out_word.sorted_value !== e.sorted_value) begin
          $error("sorted_value expected %0d got %0d", e.sorted_value, out_word.sorted_value);
          errors++;
        end
        if (out_word.last_out !== e.last_out) begin
          $error("last_out expected %0b got %0b", e.last_out, out_word.last_out);
          errors++;
        end
        if (out_word.overflow !== e.overflow) begin
          $error("overflow expected %0b got %0b", e.overflow, out_word.overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sent;
    int phase_idle[4];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single word sets at the extremes, then a small mixed set
    directed.push_back('{value: 32'sh80000000, last_in: 1'b1});
    directed.push_back('{value: 32'sh7fffffff, last_in: 1'b1});
    directed.push_back('{value: 32'sh7fffffff, last_in: 1'b0});
    directed.push_back('{value: 32'sh80000000, last_in: 1'b0});
    directed.push_back('{value: 32'sh00000000, last_in: 1'b0});
    directed.push_back('{value: -32'sd1, last_in: 1'b0});
    directed.push_back('{value: 32'sd5, last_in: 1'b0});
    directed.push_back('{value: 32'sd5, last_in: 1'b0});
    directed.push_back('{value: 32'sh55555555, last_in: 1'b0});
    directed.push_back('{value: 32'shaaaaaaaa, last_in: 1'b1});
    // two equal words
    directed.push_back('{value: 32'sd9, last_in: 1'b0});
    directed.push_back('{value: 32'sd9, last_in: 1'b1});
    foreach (directed[k]) send_word(directed[k]);
    wait_drained();

    // store full: 66 words, the last two dropped, overflow on every result
    send_set(66, 0);
    // exactly full, no overflow
    send_set(64, 1);
    wait_drained();

    // random phases: sender idle percent 0, 59, 0, then 38; the receiver never stalls
    phase_idle = '{0, 59, 0, 38};
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int s = 0; s < 2; s++) begin
        int len;
        len = $urandom_range(5, 1);
        send_set(len, $urandom_range(2));
        sent += len;
      end
      // sender holds off until every result is back
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && sorted_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
